### sv/bdm_pkg.sv
// Shared types and constants for the Bayer tile nearest-neighbor demosaic block.
// Used by the front, queue, back and top-level modules; no dependencies.
package bdm_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CoordBits  = 12;
  localparam int unsigned DimBits    = 13;
  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrBits   = $clog2(QDepth);
  localparam int unsigned QCntBits   = $clog2(QDepth + 1);

  localparam logic [DimBits-1:0] WidthReset  = DimBits'(1920);
  localparam logic [DimBits-1:0] HeightReset = DimBits'(1080);

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_PATTERN = 2'd2
  } bdm_cfg_e;

  typedef enum logic [1:0] {
    PAT_RGGB = 2'd0,
    PAT_BGGR = 2'd1,
    PAT_GRBG = 2'd2,
    PAT_GBRG = 2'd3
  } bdm_pattern_e;

  typedef enum logic [1:0] {
    PH_TL = 2'd0,
    PH_TR = 2'd1,
    PH_BL = 2'd2,
    PH_BR = 2'd3
  } bdm_phase_e;

  // One finished tile: coordinates of its bottom-right pixel and its colors
  typedef struct packed {
    logic [CoordBits-1:0]  x;
    logic [CoordBits-1:0]  y;
    logic [SampleBits-1:0] red;
    logic [SampleBits-1:0] green;
    logic [SampleBits-1:0] blue;
  } bdm_tile_t;

  typedef struct packed {
    logic [QCntBits-1:0] count;
    logic                empty;
  } bdm_qstat_t;

  function automatic logic [DimBits-1:0] clamp_dim(logic [DimBits-1:0] v,
                                                   logic [DimBits-1:0] hi);
    logic [DimBits-1:0] r;
    r = v;
    if (v < DimBits'(2)) r = DimBits'(2);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### sv/bdm_front.sv
// Front end: accepts raw samples, tracks raster position, keeps the line buffer
// and forms one tile record per completed 2x2 tile. Depends on bdm_pkg.
module bdm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bdm_pkg::SampleBits-1:0]   raw_sample_i,
  input  logic [bdm_pkg::DimBits-1:0]      width_i,
  input  logic [bdm_pkg::DimBits-1:0]      height_i,
  input  bdm_pkg::bdm_pattern_e            pattern_i,
  input  bdm_pkg::bdm_qstat_t              qstat_i,
  output logic                             push_o,
  output bdm_pkg::bdm_tile_t               tile_o
);

  logic [bdm_pkg::CoordBits-1:0]  col_q, col_d, row_q, row_d;
  logic [bdm_pkg::SampleBits-1:0] left_q;
  logic [bdm_pkg::SampleBits-1:0] line_mem [bdm_pkg::MaxWidth];
  logic [bdm_pkg::SampleBits-1:0] tl_q, tr_q, bl_q, br_q;
  logic [bdm_pkg::CoordBits-1:0]  s1_x_q, s1_y_q;
  logic                           s1_valid_q;
  logic                           accept, wr_en, rd_en;
  logic [bdm_pkg::CoordBits-1:0]  col_left;
  logic [bdm_pkg::QCntBits:0]     occupancy;
  logic [bdm_pkg::SampleBits-1:0] red, blue, g1, g2;
  logic [bdm_pkg::SampleBits:0]   gsum;

  // Hold input while the queue could not take a tile from every item in flight
  assign occupancy  = {1'b0, qstat_i.count} + (bdm_pkg::QCntBits + 1)'(s1_valid_q);
  assign in_stall_o = occupancy >= (bdm_pkg::QCntBits + 1)'(bdm_pkg::QDepth);
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_en    = accept && !row_q[0];
  assign rd_en    = accept && row_q[0] && col_q[0];
  assign col_left = col_q - bdm_pkg::CoordBits'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (({1'b0, col_q} + bdm_pkg::DimBits'(1)) >= width_i) begin
      col_d = '0;
      if (({1'b0, row_q} + bdm_pkg::DimBits'(1)) >= height_i) row_d = '0;
      else row_d = row_q + bdm_pkg::CoordBits'(1);
    end else begin
      col_d = col_q + bdm_pkg::CoordBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= rd_en;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (row_q[0] && !col_q[0]) left_q <= raw_sample_i;
      end
    end
  end

  // Line buffer: even rows write, odd rows read both top samples of the tile
  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[col_q] <= raw_sample_i;
    if (rd_en) begin
      tl_q <= line_mem[col_left];
      tr_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bl_q   <= left_q;
      br_q   <= raw_sample_i;
      s1_x_q <= col_q;
      s1_y_q <= row_q;
    end
  end

  always_comb begin
    case (pattern_i)
      bdm_pkg::PAT_RGGB: begin
        red = tl_q; g1 = tr_q; g2 = bl_q; blue = br_q;
      end
      bdm_pkg::PAT_BGGR: begin
        blue = tl_q; g1 = tr_q; g2 = bl_q; red = br_q;
      end
      bdm_pkg::PAT_GRBG: begin
        g1 = tl_q; red = tr_q; blue = bl_q; g2 = br_q;
      end
      default: begin
        g1 = tl_q; blue = tr_q; red = bl_q; g2 = br_q;
      end
    endcase
  end

  assign gsum = {1'b0, g1} + {1'b0, g2};

  assign push_o       = s1_valid_q;
  assign tile_o.x     = s1_x_q;
  assign tile_o.y     = s1_y_q;
  assign tile_o.red   = red;
  assign tile_o.green = gsum[bdm_pkg::SampleBits:1];
  assign tile_o.blue  = blue;

endmodule

### sv/bdm_queue.sv
// Short tile queue between front and back so each side can stall on its own.
// Depends on bdm_pkg for the tile record and depth.
module bdm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bdm_pkg::bdm_tile_t  push_tile_i,
  input  logic                pop_i,
  output bdm_pkg::bdm_tile_t  head_o,
  output bdm_pkg::bdm_qstat_t stat_o
);

  bdm_pkg::bdm_tile_t             entry_q [bdm_pkg::QDepth];
  logic [bdm_pkg::QPtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [bdm_pkg::QCntBits-1:0]   count_q;
  logic                           do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + bdm_pkg::QPtrBits'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + bdm_pkg::QPtrBits'(1);
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + bdm_pkg::QCntBits'(1);
        2'b01:   count_q <= count_q - bdm_pkg::QCntBits'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_tile_i;
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

### sv/bdm_back.sv
// Back end: expands each queued tile into its four pixel results, one a cycle
// unless the output stalls, through an output register. Depends on bdm_pkg.
module bdm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bdm_pkg::bdm_tile_t              head_i,
  input  bdm_pkg::bdm_qstat_t             qstat_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bdm_pkg::CoordBits-1:0]   pixel_x_o,
  output logic [bdm_pkg::CoordBits-1:0]   pixel_y_o,
  output logic [bdm_pkg::SampleBits-1:0]  red_o,
  output logic [bdm_pkg::SampleBits-1:0]  green_o,
  output logic [bdm_pkg::SampleBits-1:0]  blue_o,
  output logic                            tile_done_o
);

  bdm_pkg::bdm_phase_e            phase_q, phase_d;
  bdm_pkg::bdm_tile_t             tile_q;
  logic                           have_q, have_d;
  logic                           out_valid_q, out_valid_d;
  logic                           emit, load, last;
  logic [bdm_pkg::CoordBits-1:0]  x_q, y_q;
  logic [bdm_pkg::SampleBits-1:0] red_q, green_q, blue_q;
  logic                           done_q;

  always_comb begin
    emit        = have_q && (!out_valid_q || !out_stall_i);
    last        = (phase_q == bdm_pkg::PH_BR);
    phase_d     = phase_q;
    have_d      = have_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      case (phase_q)
        bdm_pkg::PH_TL: phase_d = bdm_pkg::PH_TR;
        bdm_pkg::PH_TR: phase_d = bdm_pkg::PH_BL;
        bdm_pkg::PH_BL: phase_d = bdm_pkg::PH_BR;
        default:        have_d  = 1'b0;
      endcase
    end
    // Take the next tile when idle or as the last pixel of this one goes out
    load = !qstat_i.empty && (!have_q || (emit && last));
    if (load) begin
      have_d  = 1'b1;
      phase_d = bdm_pkg::PH_TL;
    end
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bdm_pkg::PH_TL;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) tile_q <= head_i;
    if (emit) begin
      x_q     <= phase_q[0] ? tile_q.x : tile_q.x - bdm_pkg::CoordBits'(1);
      y_q     <= phase_q[1] ? tile_q.y : tile_q.y - bdm_pkg::CoordBits'(1);
      red_q   <= tile_q.red;
      green_q <= tile_q.green;
      blue_q  <= tile_q.blue;
      done_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = x_q;
  assign pixel_y_o   = y_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign tile_done_o = done_q;

endmodule

### sv/bayer_tile_nearest_demosaic_unit.sv
// Bayer 2x2 nearest-neighbor demosaic, top level: config registers, front, queue, back.
// A tile's results start after its bottom-right sample is accepted and follow on
// consecutive cycles unless the output stalls. Throughput: one sample per cycle on even
// rows unless stalled; on odd rows the back end's one result per cycle sets it.
// Reset clears counters and queue; the line buffer is not cleared.
module bayer_tile_nearest_demosaic_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bdm_pkg::SampleBits-1:0]  raw_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bdm_pkg::CoordBits-1:0]   pixel_x_o,
  output logic [bdm_pkg::CoordBits-1:0]   pixel_y_o,
  output logic [bdm_pkg::SampleBits-1:0]  red_o,
  output logic [bdm_pkg::SampleBits-1:0]  green_o,
  output logic [bdm_pkg::SampleBits-1:0]  blue_o,
  output logic                            tile_done_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [bdm_pkg::DimBits-1:0]     cfg_data_i
);

  logic [bdm_pkg::DimBits-1:0] width_q, height_q, width_c, height_c;
  bdm_pkg::bdm_pattern_e       pattern_q;
  bdm_pkg::bdm_tile_t          push_tile, head;
  bdm_pkg::bdm_qstat_t         qstat;
  logic                        push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= bdm_pkg::WidthReset;
      height_q  <= bdm_pkg::HeightReset;
      pattern_q <= bdm_pkg::PAT_RGGB;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdm_pkg::CFG_WIDTH:   width_q   <= cfg_data_i;
        bdm_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i;
        bdm_pkg::CFG_PATTERN: pattern_q <= bdm_pkg::bdm_pattern_e'(cfg_data_i[1:0]);
        default:              width_q   <= width_q;
      endcase
    end
  end

  assign width_c  = bdm_pkg::clamp_dim(width_q, bdm_pkg::DimBits'(bdm_pkg::MaxWidth));
  assign height_c = bdm_pkg::clamp_dim(height_q, bdm_pkg::DimBits'(bdm_pkg::MaxHeight));

  bdm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_sample_i (raw_sample_i),
    .width_i      (width_c),
    .height_i     (height_c),
    .pattern_i    (pattern_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .tile_o       (push_tile)
  );

  bdm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_tile_i (push_tile),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  bdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .tile_done_o (tile_done_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (qstat.count != bdm_pkg::QCntBits'(bdm_pkg::QDepth)))
    else $error("tile queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("tile queue popped while empty");

  a_stall_has_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !qstat.empty)
    else $error("input held with empty tile queue");

  a_done_odd_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tile_done_o) |-> (pixel_x_o[0] && pixel_y_o[0]))
    else $error("tile end flagged off the bottom-right pixel");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for bayer_tile_nearest_demosaic_unit.
// Streams raw samples and register writes through the handshakes, predicts every RGB
// pixel with a behavioral tile model and checks them in order. Depends on bdm_pkg.
module tb_top;
  import bdm_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned DrainPad    = 8;     // slack after the pending pixels drain
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned PhaseItems  = 30;
  localparam int unsigned NumDirected = 37;
  localparam int unsigned PrintCap    = 100;
  localparam logic [1:0]  CfgSpare    = 2'd3;  // unmapped register index

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [1:0]            idx;
    logic [DimBits-1:0]    data;
    logic [SampleBits-1:0] sample;
    bit                    typed;   // colors below replace the predicted ones
    logic [SampleBits-1:0] red;
    logic [SampleBits-1:0] green;
    logic [SampleBits-1:0] blue;
  } stim_row_t;

  typedef struct packed {
    logic [CoordBits-1:0]  x;
    logic [CoordBits-1:0]  y;
    logic [SampleBits-1:0] red;
    logic [SampleBits-1:0] green;
    logic [SampleBits-1:0] blue;
    logic                  done;
  } rgb_px_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [SampleBits-1:0] raw_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [CoordBits-1:0]  pixel_x_o;
  logic [CoordBits-1:0]  pixel_y_o;
  logic [SampleBits-1:0] red_o;
  logic [SampleBits-1:0] green_o;
  logic [SampleBits-1:0] blue_o;
  logic                  tile_done_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i  = '0;
  logic [DimBits-1:0]    cfg_data_i   = '0;

  // tile model state
  logic [SampleBits-1:0] line_mem [MaxWidth];
  logic [SampleBits-1:0] left_px    = '0;
  int unsigned           col_cnt    = 0;
  int unsigned           row_cnt    = 0;
  int unsigned           width_eff  = 1920;
  int unsigned           height_eff = 1080;
  bdm_pattern_e          pattern    = PAT_RGGB;
  rgb_px_t               pending_px [$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  stim_row_t script [NumDirected] = '{
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    // shrink below the column count mid-row, clamp both up to 2
    '{ROW_REG, CFG_WIDTH,   13'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_REG, CFG_HEIGHT,  13'd1,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h1111, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0000, 1'b1, 16'h0000, 16'hFFFF, 16'h0000},
    '{ROW_REG, CFG_PATTERN, 13'd1,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h1234, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0001, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hABCD, 1'b1, 16'hABCD, 16'h8000, 16'h1234},
    '{ROW_REG, CFG_PATTERN, 13'd2,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hFFFE, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h5555, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hAAAA, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0001, 1'b1, 16'h5555, 16'h7FFF, 16'hAAAA},
    '{ROW_REG, CFG_PATTERN, 13'd3,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0003, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h8001, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h7FFE, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0000, 1'b1, 16'h7FFE, 16'h0001, 16'h8001},
    // saturate high, then an odd 3x3 frame with a dropped column and a dropped row
    '{ROW_REG, CFG_WIDTH,   13'h1FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_REG, CFG_HEIGHT,  13'h1FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_REG, CFG_WIDTH,   13'd3,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_REG, CFG_HEIGHT,  13'd3,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_REG, CFG_PATTERN, 13'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_REG, CfgSpare,    13'h1FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0102, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hFEDC, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h8000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0F0F, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h3C3C, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hC3C3, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'h0001, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{ROW_PIX, CFG_WIDTH,   13'd0,    16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000}
  };

  bayer_tile_nearest_demosaic_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .tile_done_o  (tile_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned span_of(logic [DimBits-1:0] v);
    if (v < 2) return 2;
    if (v > MaxWidth) return MaxWidth;
    return v;
  endfunction

  // Store top rows, hold the bottom-left sample, emit a tile on the bottom-right one.
  function automatic void demosaic_sample(logic [SampleBits-1:0] s, bit typed,
                                          logic [SampleBits-1:0] t_r,
                                          logic [SampleBits-1:0] t_g,
                                          logic [SampleBits-1:0] t_b);
    logic [SampleBits-1:0] tl, tr, bl, r, g1, g2, b;
    logic [SampleBits:0]   gsum;
    rgb_px_t               px;
    if (!row_cnt[0]) begin
      line_mem[col_cnt] = s;
    end else if (!col_cnt[0]) begin
      left_px = s;
    end else begin
      tl = line_mem[col_cnt - 1];
      tr = line_mem[col_cnt];
      bl = left_px;
      case (pattern)
        PAT_RGGB: begin r = tl; g1 = tr; g2 = bl; b = s;  end
        PAT_BGGR: begin b = tl; g1 = tr; g2 = bl; r = s;  end
        PAT_GRBG: begin g1 = tl; r = tr; b = bl; g2 = s; end
        default:  begin g1 = tl; b = tr; r = bl; g2 = s; end
      endcase
      gsum = {1'b0, g1} + {1'b0, g2};
      px.red   = typed ? t_r : r;
      px.green = typed ? t_g : gsum[SampleBits:1];
      px.blue  = typed ? t_b : b;
      for (int k = 0; k < 4; k++) begin
        px.x    = CoordBits'(col_cnt - 1 + (k & 1));
        px.y    = CoordBits'(row_cnt - 1 + (k >> 1));
        px.done = (k == 3);
        pending_px.push_back(px);
      end
    end
    // wrap once at or past the row end; a shrunk limit wraps on the next sample
    if (col_cnt + 1 >= width_eff) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= height_eff) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatches < PrintCap) begin
      $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic feed_sample(input logic [SampleBits-1:0] s, input bit typed,
                             input logic [SampleBits-1:0] t_r,
                             input logic [SampleBits-1:0] t_g,
                             input logic [SampleBits-1:0] t_b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    demosaic_sample(s, typed, t_r, t_g, t_b);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write of a group.
  task automatic program_reg(input logic [1:0] idx, input logic [DimBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WIDTH:   width_eff  = span_of(val);
      CFG_HEIGHT:  height_eff = span_of(val);
      CFG_PATTERN: pattern    = bdm_pattern_e'(val[1:0]);
      default: ;
    endcase
  endtask

  // Hold input, drain every pending pixel, then cover the pipeline of result-free items.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic retune();
    int unsigned        pick;
    logic [DimBits-1:0] v;
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(99);
      if (pick < 80)      v = DimBits'($urandom_range(2, 9));
      else if (pick < 88) v = DimBits'($urandom_range(0, 1));
      else if (pick < 94) v = '1;
      else                v = DimBits'($urandom_range(10, 8191));
      // never widen on a bottom row: columns past the old width have no top sample
      if (!(row_cnt[0] && span_of(v) > width_eff)) program_reg(CFG_WIDTH, v);
    end
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(99);
      if (pick < 80)      v = DimBits'($urandom_range(2, 5));
      else if (pick < 88) v = DimBits'($urandom_range(0, 1));
      else if (pick < 94) v = '1;
      else                v = DimBits'($urandom_range(6, 8191));
      program_reg(CFG_HEIGHT, v);
    end
    if ($urandom_range(99) < 60) program_reg(CFG_PATTERN, DimBits'($urandom_range(0, 3)));
    if ($urandom_range(99) < 5) program_reg(CfgSpare, DimBits'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : pixel_sink
    rgb_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        note_mismatch("pixel with none pending, x", pixel_x_o, 0);
      end else begin
        want = pending_px.pop_front();
        if (pixel_x_o !== want.x)       note_mismatch("pixel_x", pixel_x_o, want.x);
        if (pixel_y_o !== want.y)       note_mismatch("pixel_y", pixel_y_o, want.y);
        if (red_o !== want.red)         note_mismatch("red", red_o, want.red);
        if (green_o !== want.green)     note_mismatch("green", green_o, want.green);
        if (blue_o !== want.blue)       note_mismatch("blue", blue_o, want.blue);
        if (tile_done_o !== want.done)  note_mismatch("tile_done", tile_done_o, want.done);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    bit                    cfg_open;
    int unsigned           fed;
    int unsigned           chunk;
    int unsigned           pick;
    logic [SampleBits-1:0] sample;
    cfg_open       = 1'b0;
    send_gap_pct   = 27;
    recv_stall_pct = 55;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      if (script[i].kind == ROW_REG) begin
        if (!cfg_open) settle();
        program_reg(script[i].idx, script[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        feed_sample(script[i].sample, script[i].typed, script[i].red, script[i].green,
                    script[i].blue);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 27 : (ph == 1) ? 55 : 0;
      recv_stall_pct = (ph == 0) ? 55 : (ph == 1) ? 27 : 0;
      fed = 0;
      while (fed < PhaseItems) begin
        settle();
        if ($urandom_range(99) < 75) retune();
        chunk = $urandom_range(4, 20);
        for (int k = 0; k < chunk; k++) begin
          pick   = $urandom_range(99);
          sample = (pick < 8) ? '0 : (pick < 16) ? '1 : SampleBits'($urandom);
          feed_sample(sample, 1'b0, '0, '0, '0);
        end
        fed += chunk;
      end
    end

    settle();
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bdm_pkg.sv
sv/bdm_front.sv
sv/bdm_queue.sv
sv/bdm_back.sv
sv/bayer_tile_nearest_demosaic_unit.sv
tb/tb_top.sv
